### rtl/jlrd_pkg.sv
// Shared types, constants and a table function for the joystick LED ring block.
package jlrd_pkg;

    // Field and register widths
    localparam int AXIS_W    = 10;
    localparam int LEVEL_W   = 8;
    localparam int DZ_W      = 9;
    localparam int DIR_W     = 4;
    localparam int IDX_W     = 4;
    localparam int ANGLE_W   = 9;
    localparam int DIST_W    = 8;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 10;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    localparam int LED_COUNT_DEF = 12;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_BASE_RED  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BASE_GRN  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BASE_BLU  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEADZONE  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_UP_THR    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DOWN_THR  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_LEFT_THR  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_RIGHT_THR = 3'd7;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_BASE_RED  = 8'd153;
    localparam logic [LEVEL_W-1:0] RST_BASE_GRN  = 8'd204;
    localparam logic [LEVEL_W-1:0] RST_BASE_BLU  = 8'd255;
    localparam logic [DZ_W-1:0]    RST_DEADZONE  = 9'd75;
    localparam logic [AXIS_W-1:0]  RST_UP_THR    = 10'd350;
    localparam logic [AXIS_W-1:0]  RST_DOWN_THR  = 10'd650;
    localparam logic [AXIS_W-1:0]  RST_LEFT_THR  = 10'd350;
    localparam logic [AXIS_W-1:0]  RST_RIGHT_THR = 10'd675;

    // Geometry
    localparam logic [AXIS_W-1:0]  AXIS_MID     = 10'd512;
    localparam logic [ANGLE_W-1:0] ANG_0        = 9'd0;
    localparam logic [ANGLE_W-1:0] ANG_90       = 9'd90;
    localparam logic [ANGLE_W-1:0] ANG_180      = 9'd180;
    localparam logic [ANGLE_W-1:0] ANG_270      = 9'd270;
    localparam logic [ANGLE_W-1:0] ANG_360      = 9'd360;
    localparam logic [ANGLE_W-1:0] LED_POS_FIRST = 9'd15;
    localparam logic [ANGLE_W-1:0] LED_POS_STEP  = 9'd30;
    localparam logic [DIST_W-1:0]  DIST_FULL    = 8'd180;
    localparam logic [DIST_W-1:0]  DIST_CUT     = 8'd158;
    localparam int                 JUMP_LED_LAST = 5;
    localparam logic [IDX_W-1:0]   LED_IDX_MAX  = 4'd11;

    // Shared multiplier port widths
    localparam int TAB_DEPTH = 91;
    localparam int TAB_AW    = 7;
    localparam int TAB_W     = 60;
    localparam int MA_W      = 17;
    localparam int MB_W      = 16;
    localparam int PROD_W    = TAB_W + MB_W;

    localparam logic [TAB_AW-1:0] TAB_LAST = 7'd90;
    localparam int SEARCH_STEPS = 7;

    // floor(p / 225) = (p * RECIP_225) >> RECIP_SHIFT for every p below 125000
    localparam logic [MA_W-1:0] RECIP_225   = 17'd74566;
    localparam int              RECIP_SHIFT = 24;

    // Sine table in decimal fixed point, one unit is 1e-18
    localparam logic [127:0] SIN_ONE = 128'd1000000000000000000;
    localparam logic [127:0] SIN_1DEG = 128'd17452406437283513;
    localparam logic [127:0] COS_1DEG = 128'd999847695156391239;

    typedef struct packed {
        logic              tab;
        logic [TAB_AW-1:0] addr;
        logic [MA_W-1:0]   a;
        logic [MB_W-1:0]   b;
    } mul_req_t;

    // Sine of k whole degrees, built by repeated rotation through one degree.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [TAB_W-1:0] sin_deg(input int k);
        logic [127:0] s;
        logic [127:0] c;
        logic [127:0] ns;
        logic [127:0] nc;
        s = '0;
        c = SIN_ONE;
        for (int j = 0; j < TAB_DEPTH; j++) begin
            if (j < k) begin
                ns = (s * COS_1DEG + c * SIN_1DEG) / SIN_ONE;
                nc = (c * COS_1DEG - s * SIN_1DEG) / SIN_ONE;
                s  = ns;
                c  = nc;
            end
        end
        return s[TAB_W-1:0];
    endfunction

endpackage

### rtl/jlrd_mul_unit.sv
// Shared multiplier with the whole-degree sine table on its wide operand.
module jlrd_mul_unit
(
    input  jlrd_pkg::mul_req_t              req,
    output logic [jlrd_pkg::PROD_W-1:0]     prod
);

    logic [jlrd_pkg::TAB_W-1:0] sin_rom [jlrd_pkg::TAB_DEPTH];
    logic [jlrd_pkg::TAB_W-1:0] a_op;

    for (genvar g = 0; g < jlrd_pkg::TAB_DEPTH; g++)
    begin : g_sin
        localparam logic [jlrd_pkg::TAB_W-1:0] SIN_VAL = jlrd_pkg::sin_deg(g);
        assign sin_rom[g] = SIN_VAL;
    end

    always_comb
    begin
        if (req.tab)
        begin
            a_op = sin_rom[req.addr];
        end
        else
        begin
            a_op = {{(jlrd_pkg::TAB_W - jlrd_pkg::MA_W){1'b0}}, req.a};
        end
    end

    assign prod = {{jlrd_pkg::MB_W{1'b0}}, a_op}
                * {{jlrd_pkg::TAB_W{1'b0}}, req.b};

endmodule

### rtl/joystick_led_ring_direction.sv
// Top level: joystick direction decode and LED ring color sequencer.
//
//  channel | dir | fields (low bit first)
//  --------+-----+--------------------------------------------------------------
//  s_*     | in  | tdata: joystick_x[9:0], joystick_y[19:10], jump_pressed[20]
//  m_*     | out | tdata: led_index, red, green, blue, direction_code; tlast: last_led
//  cfg_*   | in  | write enable, register index, write data
//
// One sample runs a setup step, an angle search unless the ring fades or the angle is
// fixed, and then each LED in turn; the single multiplier sets the pace: seven
// binary-search steps of two products each for the angle, six products per LED drawn.
// An LED past the cutoff or a faded LED takes no product.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register and a stalled m_tready holds the sequencer in its output step.
// Reset clears the ring to black and loads the register defaults.
module joystick_led_ring_direction
#(
    parameter int LED_COUNT = jlrd_pkg::LED_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // joystick_x, joystick_y, jump_pressed, zero fill
    input  logic [jlrd_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // led_index, red_level, green_level, blue_level, direction_code
    output logic [jlrd_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [jlrd_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [jlrd_pkg::CFG_DW-1:0]       cfg_data
);

    localparam int LIW = $clog2(LED_COUNT);
    localparam logic [LIW-1:0] LED_LAST  = LIW'(LED_COUNT - 1);
    localparam logic [LIW-1:0] JUMP_LAST = LIW'(jlrd_pkg::JUMP_LED_LAST);
    localparam int AW  = jlrd_pkg::AXIS_W;
    localparam int LW  = jlrd_pkg::LEVEL_W;
    localparam int ANW = jlrd_pkg::ANGLE_W;
    localparam int DW  = jlrd_pkg::DIST_W;
    localparam int TAW = jlrd_pkg::TAB_AW;
    localparam int PW  = jlrd_pkg::PROD_W;
    localparam int IW  = jlrd_pkg::IDX_W;
    localparam int CW  = 3 * LW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_SRCH_A = 3'd2;
    localparam logic [2:0] ST_SRCH_B = 3'd3;
    localparam logic [2:0] ST_LED    = 3'd4;
    localparam logic [2:0] ST_MUL1   = 3'd5;
    localparam logic [2:0] ST_MUL2   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam logic [1:0] CH_RED = 2'd0;
    localparam logic [1:0] CH_GRN = 2'd1;
    localparam logic [1:0] CH_BLU = 2'd2;

    // Configuration registers
    logic [LW-1:0]                base_red_reg, base_grn_reg, base_blu_reg;
    logic [jlrd_pkg::DZ_W-1:0]    dz_reg;
    logic [AW-1:0]                up_reg, down_reg, left_reg, right_reg;

    // Sequencer and datapath
    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       x_reg, x_next, y_reg, y_next;
    logic                jump_reg, jump_next;
    logic [jlrd_pkg::DIR_W-1:0] dir_reg, dir_next;
    logic                idle_reg, idle_next;
    logic [AW-1:0]       u_reg, u_next, v_reg, v_next;
    logic [ANW-1:0]      quad_reg, quad_next;
    logic [TAW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [2:0]          iter_reg, iter_next;
    logic [ANW-1:0]      ang_reg, ang_next;
    logic [LIW-1:0]      led_reg, led_next;
    logic [ANW-1:0]      pos_reg, pos_next;
    logic [DW-1:0]       dist_reg, dist_next;
    logic [1:0]          chan_reg, chan_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [jlrd_pkg::MB_W-1:0] p_reg, p_next;
    logic [CW-1:0]       color_reg, color_next;
    logic [CW-1:0]       ring_reg [LED_COUNT];
    logic                ring_we;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [jlrd_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // Shared multiplier
    jlrd_pkg::mul_req_t  mreq;
    logic [PW-1:0]       prod;

    jlrd_mul_unit u_mul
    (
        .req  (mreq),
        .prod (prod)
    );

    // Centered offsets, negated as the angle rule uses them
    logic signed [AW:0]  a_s, b_s;
    logic [AW-1:0]       ax, ay;
    logic                idle_c;
    logic [jlrd_pkg::DIR_W-1:0] dir_c;
    logic [AW-1:0]       u_c, v_c;
    logic [ANW-1:0]      quad_c;
    logic                spec_c;
    logic [ANW-1:0]      spec_ang_c;

    assign a_s = $signed({1'b0, jlrd_pkg::AXIS_MID}) - $signed({1'b0, x_reg});
    assign b_s = $signed({1'b0, jlrd_pkg::AXIS_MID}) - $signed({1'b0, y_reg});

    always_comb
    begin
        logic [AW:0] na;
        logic [AW:0] nb;
        na = -a_s;
        nb = -b_s;
        ax = (a_s < 0) ? na[AW-1:0] : a_s[AW-1:0];
        ay = (b_s < 0) ? nb[AW-1:0] : b_s[AW-1:0];
        idle_c = (ax < {1'b0, dz_reg}) && (ay < {1'b0, dz_reg});

        dir_c[3] = (x_reg < up_reg) || jump_reg;
        dir_c[2] = x_reg > down_reg;
        dir_c[1] = y_reg < left_reg;
        dir_c[0] = y_reg > right_reg;

        if (a_s >= 0 && b_s > 0)
        begin
            quad_c = jlrd_pkg::ANG_0;
            u_c    = a_s[AW-1:0];
            v_c    = b_s[AW-1:0];
        end
        else if (a_s > 0)
        begin
            quad_c = jlrd_pkg::ANG_90;
            u_c    = nb[AW-1:0];
            v_c    = a_s[AW-1:0];
        end
        else if (b_s < 0)
        begin
            quad_c = jlrd_pkg::ANG_180;
            u_c    = na[AW-1:0];
            v_c    = nb[AW-1:0];
        end
        else
        begin
            quad_c = jlrd_pkg::ANG_270;
            u_c    = b_s[AW-1:0];
            v_c    = na[AW-1:0];
        end

        // A centered stick points at 180; straight back along the second axis is 360.
        spec_c     = (x_reg == jlrd_pkg::AXIS_MID) && (y_reg <= jlrd_pkg::AXIS_MID);
        spec_ang_c = (y_reg == jlrd_pkg::AXIS_MID) ? jlrd_pkg::ANG_180 : jlrd_pkg::ANG_360;
    end

    // Binary search midpoint over whole degrees
    logic [TAW:0]   mid_sum;
    logic [TAW-1:0] mid;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[TAW:1];

    // Circular distance from the current LED to its target angle
    logic [ANW-1:0] tgt;
    logic [ANW-1:0] dabs;
    logic [ANW-1:0] dwrap;
    logic [DW-1:0]  dist_c;
    logic           jump_led;

    assign jump_led = jump_reg && (led_reg <= JUMP_LAST);
    assign tgt      = jump_led ? jlrd_pkg::ANG_90 : ang_reg;
    assign dabs     = (pos_reg > tgt) ? (pos_reg - tgt) : (tgt - pos_reg);
    assign dwrap    = (dabs > jlrd_pkg::ANG_180) ? (jlrd_pkg::ANG_360 - dabs) : dabs;
    assign dist_c   = dwrap[DW-1:0];

    logic [LW-1:0]  base_sel;
    logic [LW-1:0]  lvl;
    logic [DW-1:0]  span;
    logic           out_free;

    assign lvl      = prod[jlrd_pkg::RECIP_SHIFT +: LW];
    assign span     = jlrd_pkg::DIST_FULL - dist_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        case (chan_reg)
            CH_RED:  base_sel = base_red_reg;
            CH_GRN:  base_sel = base_grn_reg;
            default: base_sel = base_blu_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        jump_next  = jump_reg;
        dir_next   = dir_reg;
        idle_next  = idle_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        quad_next  = quad_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        iter_next  = iter_reg;
        ang_next   = ang_reg;
        led_next   = led_reg;
        pos_next   = pos_reg;
        dist_next  = dist_reg;
        chan_next  = chan_reg;
        prod_next  = prod_reg;
        p_next     = p_reg;
        color_next = color_reg;
        ring_we    = 1'b0;
        mreq       = '0;

        m_tvalid_next = (m_tvalid_reg && !m_tready);
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata[AW-1:0];
                    y_next     = s_tdata[2*AW-1:AW];
                    jump_next  = s_tdata[2*AW];
                    led_next   = '0;
                    pos_next   = jlrd_pkg::LED_POS_FIRST;
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                dir_next  = dir_c;
                idle_next = idle_c;
                u_next    = u_c;
                v_next    = v_c;
                quad_next = quad_c;
                lo_next   = '0;
                hi_next   = jlrd_pkg::TAB_LAST;
                iter_next = '0;
                if (idle_c)
                begin
                    state_next = ST_LED;
                end
                else if (spec_c)
                begin
                    ang_next   = spec_ang_c;
                    state_next = ST_LED;
                end
                else
                begin
                    state_next = ST_SRCH_A;
                end
            end

            ST_SRCH_A:
            begin
                // u * cos(mid)
                mreq.tab   = 1'b1;
                mreq.addr  = jlrd_pkg::TAB_LAST - mid;
                mreq.b     = {{(jlrd_pkg::MB_W - AW){1'b0}}, u_reg};
                prod_next  = prod;
                state_next = ST_SRCH_B;
            end

            ST_SRCH_B:
            begin
                // Compare against v * sin(mid); the test is monotone in the degree.
                mreq.tab  = 1'b1;
                mreq.addr = mid;
                mreq.b    = {{(jlrd_pkg::MB_W - AW){1'b0}}, v_reg};
                if (prod_reg >= prod)
                begin
                    lo_next = mid;
                end
                else
                begin
                    hi_next = mid;
                end
                iter_next = iter_reg + 3'd1;
                if (iter_reg == 3'(jlrd_pkg::SEARCH_STEPS - 1))
                begin
                    ang_next   = quad_reg + {{(ANW - TAW){1'b0}}, lo_next};
                    state_next = ST_LED;
                end
                else
                begin
                    state_next = ST_SRCH_A;
                end
            end

            ST_LED:
            begin
                dist_next = dist_c;
                chan_next = CH_RED;
                if (idle_reg && !jump_led)
                begin
                    if (jump_reg)
                    begin
                        color_next = '0;
                    end
                    else
                    begin
                        color_next = (ring_reg[led_reg] >> 1) & 24'h7F7F7F;
                    end
                    state_next = ST_OUT;
                end
                else if (dist_c >= jlrd_pkg::DIST_CUT)
                begin
                    color_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end

            ST_MUL1:
            begin
                mreq.a     = {{(jlrd_pkg::MA_W - LW){1'b0}}, base_sel};
                mreq.b     = {{(jlrd_pkg::MB_W - DW){1'b0}}, span};
                p_next     = prod[jlrd_pkg::MB_W-1:0];
                state_next = ST_MUL2;
            end

            ST_MUL2:
            begin
                mreq.a = jlrd_pkg::RECIP_225;
                mreq.b = p_reg;
                case (chan_reg)
                    CH_RED:  color_next[3*LW-1:2*LW] = lvl;
                    CH_GRN:  color_next[2*LW-1:LW]   = lvl;
                    default: color_next[LW-1:0]      = lvl;
                endcase
                if (chan_reg == CH_BLU)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_MUL1;
                end
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    ring_we       = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_data_next   = {dir_reg, color_reg[LW-1:0], color_reg[2*LW-1:LW],
                                     color_reg[3*LW-1:2*LW], IW'(led_reg)};
                    m_last_next   = (led_reg == LED_LAST);
                    if (led_reg == LED_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        led_next   = led_reg + LIW'(1);
                        pos_next   = pos_reg + jlrd_pkg::LED_POS_STEP;
                        state_next = ST_LED;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg <= jlrd_pkg::RST_BASE_RED;
            base_grn_reg <= jlrd_pkg::RST_BASE_GRN;
            base_blu_reg <= jlrd_pkg::RST_BASE_BLU;
            dz_reg       <= jlrd_pkg::RST_DEADZONE;
            up_reg       <= jlrd_pkg::RST_UP_THR;
            down_reg     <= jlrd_pkg::RST_DOWN_THR;
            left_reg     <= jlrd_pkg::RST_LEFT_THR;
            right_reg    <= jlrd_pkg::RST_RIGHT_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                jlrd_pkg::REG_BASE_RED:  base_red_reg <= cfg_data[LW-1:0];
                jlrd_pkg::REG_BASE_GRN:  base_grn_reg <= cfg_data[LW-1:0];
                jlrd_pkg::REG_BASE_BLU:  base_blu_reg <= cfg_data[LW-1:0];
                jlrd_pkg::REG_DEADZONE:  dz_reg       <= cfg_data[jlrd_pkg::DZ_W-1:0];
                jlrd_pkg::REG_UP_THR:    up_reg       <= cfg_data[AW-1:0];
                jlrd_pkg::REG_DOWN_THR:  down_reg     <= cfg_data[AW-1:0];
                jlrd_pkg::REG_LEFT_THR:  left_reg     <= cfg_data[AW-1:0];
                jlrd_pkg::REG_RIGHT_THR: right_reg    <= cfg_data[AW-1:0];
                default:                 right_reg    <= right_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (ring_we)
            begin
                ring_reg[led_reg] <= color_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        jump_reg   <= jump_next;
        dir_reg    <= dir_next;
        idle_reg   <= idle_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        quad_reg   <= quad_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        iter_reg   <= iter_next;
        ang_reg    <= ang_next;
        led_reg    <= led_next;
        pos_reg    <= pos_next;
        dist_reg   <= dist_next;
        chan_reg   <= chan_next;
        prod_reg   <= prod_next;
        p_reg      <= p_next;
        color_reg  <= color_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### rtl/jlrd_checker.sv
// Port-level checks for the joystick LED ring block, bound to the top level.
module jlrd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [jlrd_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    // A taken sample makes the block busy, so it does not accept another straight away.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // The frame marker sits on the final ring position only.
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[jlrd_pkg::IDX_W-1:0] == jlrd_pkg::LED_IDX_MAX)))
        else $error("last flag out of place");

    // Results are numbered in ring order, one step per accepted result.
    a_led_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
        (m_tdata[jlrd_pkg::IDX_W-1:0] == $past(m_tdata[jlrd_pkg::IDX_W-1:0]) + 4'd1))
        else $error("LED index out of sequence");

endmodule

bind joystick_led_ring_direction jlrd_checker u_jlrd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the joystick LED ring direction block.
module testbench;
    import jlrd_pkg::*;

    localparam int LEDS      = LED_COUNT_DEF;
    localparam int LONG_HOLD = 600;

    typedef struct packed {
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        logic              jump;
    } sample_t;

    typedef struct packed {
        logic [IDX_W-1:0]   led;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [DIR_W-1:0]   dir;
        logic               last;
    } led_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_AW-1:0]     cfg_addr = '0;
    logic [CFG_DW-1:0]     cfg_data = '0;

    // Local copy of the register file and of the ring colors
    logic [LEVEL_W-1:0] lvl_red, lvl_grn, lvl_blu;
    logic [DZ_W-1:0]    dz_radius;
    logic [AXIS_W-1:0]  thr_up, thr_down, thr_left, thr_right;
    logic [23:0]        ring_now [0:LEDS-1];
    real                sin_deg_r [0:90];

    sample_t     samples_pending [$];
    led_result_t leds_due [$];
    sample_t     on_bus;
    led_result_t seen, due;

    logic quiet = 1'b1;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   rx_wait = 0;
    int   sender_gap = 0;
    int   failures = 0;
    int   samples_sent = 0;
    int   results_checked = 0;
    int   fades_seen = 0;
    int   redraws_seen = 0;
    int   jumps_seen = 0;
    int   settings_used = 0;

    joystick_led_ring_direction i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(20, 120);
    endfunction

    // Whole-degree stick heading in 0..360, taken from the quadrant and a
    // linear search over the tangent of each degree.
    function automatic int stick_heading(int sx, int sy);
        int  a, b, quad, fl, k;
        real u, v;
        a = -sx;
        b = -sy;
        if (sx == 0 && sy == 0) return int'(ANG_180);
        if (sx == 0 && sy < 0) return int'(ANG_360);
        if (a >= 0 && b > 0)
        begin
            quad = int'(ANG_0); u = a; v = b;
        end
        else if (a > 0)
        begin
            quad = int'(ANG_90); u = -b; v = a;
        end
        else if (b < 0)
        begin
            quad = int'(ANG_180); u = -a; v = -b;
        end
        else
        begin
            quad = int'(ANG_270); u = b; v = -a;
        end
        fl = 0;
        for (k = 1; k < 90 && u * sin_deg_r[90 - k] >= v * sin_deg_r[k]; k++)
            fl = k;
        return quad + fl;
    endfunction

    function automatic logic [LEVEL_W-1:0] glow(int d, logic [LEVEL_W-1:0] full);
        if (d >= int'(DIST_CUT)) return '0;
        return LEVEL_W'(((int'(DIST_FULL) - d) * int'(full)) / 225);
    endfunction

    function automatic logic [23:0] draw_led(int i, int heading);
        int pos, span, d;
        pos  = int'(LED_POS_FIRST) + int'(LED_POS_STEP) * i;
        span = pos > heading ? pos - heading : heading - pos;
        d    = span > 180 ? 360 - span : span;
        return {glow(d, lvl_red), glow(d, lvl_grn), glow(d, lvl_blu)};
    endfunction

    // Updates the ring for one accepted sample and queues its twelve colors.
    task automatic predict_sample(input sample_t s);
        int          sx, sy, ax, ay, heading, i;
        logic        idle;
        logic [DIR_W-1:0] dir;
        led_result_t r;
        sx = int'(s.x) - int'(AXIS_MID);
        sy = int'(s.y) - int'(AXIS_MID);
        ax = sx < 0 ? -sx : sx;
        ay = sy < 0 ? -sy : sy;
        idle = (ax < int'(dz_radius)) && (ay < int'(dz_radius));
        dir = {(s.x < thr_up) || s.jump, s.x > thr_down, s.y < thr_left, s.y > thr_right};
        if (idle)
        begin
            fades_seen++;
            for (i = 0; i < LEDS; i++)
                ring_now[i] = (s.jump) ? 24'h0 : (ring_now[i] >> 1) & 24'h7F7F7F;
        end
        else
        begin
            redraws_seen++;
            heading = stick_heading(sx, sy);
            for (i = 0; i < LEDS; i++)
                ring_now[i] = draw_led(i, heading);
        end
        if (s.jump)
        begin
            jumps_seen++;
            for (i = 0; i <= JUMP_LED_LAST; i++)
                ring_now[i] = draw_led(i, int'(ANG_90));
        end
        for (i = 0; i < LEDS; i++)
        begin
            r.led   = IDX_W'(i);
            r.red   = ring_now[i][23:16];
            r.green = ring_now[i][15:8];
            r.blue  = ring_now[i][7:0];
            r.dir   = dir;
            r.last  = (i == LEDS - 1);
            leds_due.push_back(r);
        end
    endtask

    // Request driver: a new sample is presented once the previous one is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_sample(on_bus);
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sender_gap > 0)
                begin
                    sender_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (samples_pending.size() > 0)
                begin
                    on_bus = samples_pending.pop_front();
                    s_tdata <= {3'b000, on_bus.jump, on_bus.y, on_bus.x};
                    s_tvalid <= 1'b1;
                    sender_gap = quiet ? 0 : pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls plus the occasional long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            rx_wait = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                rx_wait = pick_gap();
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = {m_tdata[3:0], m_tdata[11:4], m_tdata[19:12], m_tdata[27:20],
                    m_tdata[31:28], m_tlast};
            if (leds_due.size() == 0)
            begin
                if (failures < 10)
                    $display("%0t: LED result with none expected: led %0d rgb %0d %0d %0d",
                             $realtime, seen.led, seen.red, seen.green, seen.blue);
                failures++;
            end
            else
            begin
                due = leds_due.pop_front();
                results_checked++;
                if (seen !== due)
                begin
                    if (failures < 10)
                    begin
                        $write("%0t: mismatch led/r/g/b/dir/last expected %0d/%0d/%0d/%0d/%h/%b",
                               $realtime, due.led, due.red, due.green, due.blue,
                               due.dir, due.last);
                        $display(" got %0d/%0d/%0d/%0d/%h/%b", seen.led, seen.red,
                                 seen.green, seen.blue, seen.dir, seen.last);
                    end
                    failures++;
                end
            end
        end
    end

    task automatic set_reg(input logic [CFG_AW-1:0] idx, input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DW'(value);
        case (idx)
            REG_BASE_RED:  lvl_red   = LEVEL_W'(value);
            REG_BASE_GRN:  lvl_grn   = LEVEL_W'(value);
            REG_BASE_BLU:  lvl_blu   = LEVEL_W'(value);
            REG_DEADZONE:  dz_radius = DZ_W'(value);
            REG_UP_THR:    thr_up    = AXIS_W'(value);
            REG_DOWN_THR:  thr_down  = AXIS_W'(value);
            REG_LEFT_THR:  thr_left  = AXIS_W'(value);
            default:       thr_right = AXIS_W'(value);
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_settings(input int r, input int g, input int b, input int dz,
                                  input int up, input int dn, input int lf, input int rt);
        set_reg(REG_BASE_RED, r);
        set_reg(REG_BASE_GRN, g);
        set_reg(REG_BASE_BLU, b);
        set_reg(REG_DEADZONE, dz);
        set_reg(REG_UP_THR, up);
        set_reg(REG_DOWN_THR, dn);
        set_reg(REG_LEFT_THR, lf);
        set_reg(REG_RIGHT_THR, rt);
        settings_used++;
    endtask

    task automatic send(input int x, input int y, input bit jump);
        sample_t s;
        s.x = AXIS_W'(x);
        s.y = AXIS_W'(y);
        s.jump = jump;
        samples_pending.push_back(s);
    endtask

    // Waits until every sample is taken, every color has arrived and the block is idle.
    task automatic drain();
        while (samples_pending.size() != 0 || s_tvalid || leds_due.size() != 0)
            @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        int      r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            s.x = AXIS_W'($urandom_range(392, 632));
            s.y = AXIS_W'($urandom_range(392, 632));
        end
        else
        begin
            s.x = AXIS_W'($urandom_range(0, 1023));
            s.y = AXIS_W'($urandom_range(0, 1023));
        end
        // Stick on one axis now and then
        if (r == 9)
        begin
            if ($urandom_range(0, 1)) s.x = AXIS_MID; else s.y = AXIS_MID;
        end
        s.jump = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    initial
    begin
        int i, ph, n;
        for (i = 0; i <= 90; i++)
            sin_deg_r[i] = $sin(i * 3.14159265358979323846 / 180.0);
        for (i = 0; i < LEDS; i++)
            ring_now[i] = '0;
        lvl_red   = RST_BASE_RED;
        lvl_grn   = RST_BASE_GRN;
        lvl_blu   = RST_BASE_BLU;
        dz_radius = RST_DEADZONE;
        thr_up    = RST_UP_THR;
        thr_down  = RST_DOWN_THR;
        thr_left  = RST_LEFT_THR;
        thr_right = RST_RIGHT_THR;
        settings_used = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: fades, both stick-on-axis angles, diagonals, deadzone and
        // threshold boundaries, jump inside and outside the deadzone.
        send(512, 512, 0);
        send(0, 512, 0);
        send(512, 512, 0);
        send(560, 470, 0);
        send(512, 512, 1);
        send(512, 0, 0);
        send(512, 1023, 0);
        send(1023, 1023, 1);
        send(0, 0, 0);
        send(1023, 0, 0);
        send(0, 1023, 1);
        send(600, 600, 0);
        send(424, 424, 0);
        send(586, 438, 0);
        send(587, 512, 0);
        send(437, 512, 0);
        send(349, 349, 0);
        send(350, 350, 0);
        send(650, 675, 0);
        send(651, 676, 1);
        drain();

        // Full-scale colors and no deadzone: a centered stick is drawn at 180.
        write_settings(255, 255, 255, 0, 0, 1023, 0, 1023);
        send(512, 512, 0);
        send(512, 512, 1);
        send(512, 0, 0);
        send(511, 513, 0);
        send(1023, 511, 0);
        drain();

        // Black colors and the widest deadzone, with random stick positions.
        write_settings(0, 0, 0, 511, 1023, 0, 1023, 0);
        quiet <= 1'b0;
        for (n = 0; n < 20; n++)
            samples_pending.push_back(rand_sample());
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                write_settings(RST_BASE_RED, RST_BASE_GRN, RST_BASE_BLU, RST_DEADZONE,
                               RST_UP_THR, RST_DOWN_THR, RST_LEFT_THR, RST_RIGHT_THR);
            else
                write_settings($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 150),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023));
            quiet <= (ph == 1);
            for (n = 0; n < 32; n++)
                samples_pending.push_back(rand_sample());
            // The receiver holds off while samples keep coming, so the block backs up.
            if (ph == 2)
            begin
                @(posedge clk);
                holds_asked <= holds_asked + 1;
            end
            drain();
        end

        repeat (150) @(posedge clk);
        $display("Sent %0d joystick samples (%0d redraws, %0d fades, %0d with jump);",
                 samples_sent, redraws_seen, fades_seen, jumps_seen);
        $display("checked %0d LED colors over %0d register settings.",
                 results_checked, settings_used);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/jlrd_pkg.sv
rtl/jlrd_mul_unit.sv
rtl/joystick_led_ring_direction.sv
rtl/jlrd_checker.sv
test/testbench.sv
